FILE: rtl/tcs_pkg.sv
// Shared types and constants for the touch calibrate and stabilize block.
// Holds the transaction payload structs, divider status and register codes.
// Depends on nothing; every other file imports it.
package tcs_pkg;

   // Field widths of the transaction payloads and the configuration port.
   localparam int RAW_W       = 12;
   localparam int XPOS_W      = 9;
   localparam int YPOS_W      = 8;
   localparam int CNT_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   // Position arithmetic is sized for screens of up to 4096 pixels per axis.
   localparam int POS_W      = 12;
   localparam int SPAN_W     = 12;
   localparam int DIVISOR_W  = 12;
   localparam int DIVIDEND_W = RAW_W + SPAN_W;

   // Saturation value of the stable-sample counter.
   localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_X_LEFT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_RIGHT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_TOP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_BOTTOM  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [RAW_W-1:0] X_LEFT_RESET    = 12'd3857;
   localparam logic [RAW_W-1:0] X_RIGHT_RESET   = 12'd239;
   localparam logic [RAW_W-1:0] Y_TOP_RESET     = 12'd213;
   localparam logic [RAW_W-1:0] Y_BOTTOM_RESET  = 12'd3693;
   localparam logic [CNT_W-1:0] TOLERANCE_RESET = 8'd8;
   localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd0;

   // One touch sample.
   typedef struct packed {
      logic             touched;
      logic [RAW_W-1:0] raw_x;
      logic [RAW_W-1:0] raw_y;
   } tcs_req_type;

   // One result: press state and the last stable position.
   typedef struct packed {
      logic              pressed;
      logic [XPOS_W-1:0] x_pos;
      logic [YPOS_W-1:0] y_pos;
   } tcs_rsp_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } tcs_div_status_type;

endpackage

FILE: rtl/tcs_div.sv
// Restoring unsigned divider, one quotient bit per clock cycle.
// Shared by both axes of the calibration map; uses tcs_pkg widths and types.
module tcs_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tcs_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [tcs_pkg::DIVISOR_W-1:0]  divisor,
   output tcs_pkg::tcs_div_status_type    status,
   output logic [tcs_pkg::DIVIDEND_W-1:0] quotient
);
   import tcs_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W+1:0]  trial;
   logic                  borrow;

   // One shift-and-subtract step of the restoring division.
   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, den_ff};
   assign borrow    = trial[DIVISOR_W+1];

   // Sequencing of the iterations.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], ~borrow};
         rem_in  = borrow ? rem_shift[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Operand and result registers carry no reset.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   // A new division never starts on top of a running one.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // The last iteration is followed by the done pulse.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == LAST_STEP) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after its last step");

   // Done is a single pulse outside the busy window.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && !$past(done_ff)))
      else $error("divider done overlaps busy or lasts two cycles");

endmodule

FILE: rtl/touch_calibrate_and_stabilize.sv
// Touch sample calibration to screen coordinates with press debounce; uses tcs_pkg, tcs_div.
// A touched sample is mapped axis by axis, and the next sample is accepted only after its
// result is committed: per axis a multiply, a load, 24 divide steps and a done step
// on the one shared divider, then the update step. A sample without touch goes straight
// to the update step. A stalled result holds the update step. Synchronous active-high
// reset clears the sequencer and tracking state.
module touch_calibrate_and_stabilize #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tcs_pkg::tcs_req_type            req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tcs_pkg::tcs_rsp_type            rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcs_pkg::*;

   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam logic [SPAN_W-1:0] SPAN_M1_X = SPAN_W'(SCREEN_WIDTH - 1);
   localparam logic [SPAN_W-1:0] SPAN_M1_Y = SPAN_W'(SCREEN_HEIGHT - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_UPDATE = 5'b10000
   } tcs_state_type;

   tcs_state_type state_ff, state_in;
   logic          axis_ff, axis_in;

   logic [RAW_W-1:0] x_left_ff, x_right_ff, y_top_ff, y_bottom_ff;
   logic [CNT_W-1:0] tol_ff, thr_ff;

   logic             touched_ff;
   logic [RAW_W-1:0] raw_x_ff, raw_y_ff;

   logic [DIVIDEND_W-1:0] prod_ff;
   logic [DIVISOR_W-1:0]  den_mag_ff;
   logic                  neg_ff, zero_ff;
   logic [XW-1:0]         x_val_ff;
   logic [YW-1:0]         y_val_ff;

   logic [XW-1:0]    prev_x_ff, prev_x_in, held_x_ff, held_x_in;
   logic [YW-1:0]    prev_y_ff, prev_y_in, held_y_ff, held_y_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   tcs_rsp_type rsp_payload_ff;
   logic        pressed_c;

   logic [RAW_W-1:0]      raw_sel, lo_sel, hi_sel;
   logic [SPAN_W-1:0]     span_m1_sel;
   logic [RAW_W:0]        num_diff, num_neg, den_diff, den_neg;
   logic [RAW_W-1:0]      num_mag;
   logic [DIVIDEND_W-1:0] prod_c;
   logic [POS_W-1:0]      axis_result;

   logic                  div_start;
   tcs_div_status_type    div_status;
   logic [DIVIDEND_W-1:0] div_quotient;

   logic [XW-1:0] dist_x;
   logic [YW-1:0] dist_y;
   logic          stable_c;
   logic          commit;

   // Configuration registers, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_left_ff   <= X_LEFT_RESET;
         x_right_ff  <= X_RIGHT_RESET;
         y_top_ff    <= Y_TOP_RESET;
         y_bottom_ff <= Y_BOTTOM_RESET;
         tol_ff      <= TOLERANCE_RESET;
         thr_ff      <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_X_LEFT:    x_left_ff   <= csr_wdata[RAW_W-1:0];
            CSR_X_RIGHT:   x_right_ff  <= csr_wdata[RAW_W-1:0];
            CSR_Y_TOP:     y_top_ff    <= csr_wdata[RAW_W-1:0];
            CSR_Y_BOTTOM:  y_bottom_ff <= csr_wdata[RAW_W-1:0];
            CSR_TOLERANCE: tol_ff      <= csr_wdata[CNT_W-1:0];
            CSR_THRESHOLD: thr_ff      <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Operand selection for the axis in progress.
   assign raw_sel     = axis_ff ? raw_y_ff    : raw_x_ff;
   assign lo_sel      = axis_ff ? y_top_ff    : x_left_ff;
   assign hi_sel      = axis_ff ? y_bottom_ff : x_right_ff;
   assign span_m1_sel = axis_ff ? SPAN_M1_Y   : SPAN_M1_X;

   // Signed offsets split into magnitude and sign; the quotient sign is their xor.
   assign num_diff = {1'b0, raw_sel} - {1'b0, lo_sel};
   assign den_diff = {1'b0, hi_sel} - {1'b0, lo_sel};
   assign num_neg  = -num_diff;
   assign den_neg  = -den_diff;
   assign num_mag  = num_diff[RAW_W] ? num_neg[RAW_W-1:0] : num_diff[RAW_W-1:0];
   assign prod_c   = DIVIDEND_W'(num_mag) * DIVIDEND_W'(span_m1_sel);

   // Multiply stage result registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff    <= prod_c;
         den_mag_ff <= den_diff[RAW_W] ? den_neg[RAW_W-1:0] : den_diff[RAW_W-1:0];
         neg_ff     <= num_diff[RAW_W] ^ den_diff[RAW_W];
         zero_ff    <= (den_diff == '0);
      end
   end

   assign div_start = (state_ff == ST_LOAD);

   tcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_mag_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // A negative quotient or equal endpoints give zero; large values clamp.
   always_comb begin
      if (zero_ff || neg_ff) begin
         axis_result = '0;
      end else if (div_quotient > DIVIDEND_W'(span_m1_sel)) begin
         axis_result = POS_W'(span_m1_sel);
      end else begin
         axis_result = div_quotient[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && div_status.done) begin
         if (axis_ff) begin
            y_val_ff <= axis_result[YW-1:0];
         end else begin
            x_val_ff <= axis_result[XW-1:0];
         end
      end
   end

   // Capture of the accepted sample.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         touched_ff <= req_payload.touched;
         raw_x_ff   <= req_payload.raw_x;
         raw_y_ff   <= req_payload.raw_y;
      end
   end

   // Sequencer: for a touched sample map X, then Y, then update the debounce state.
   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               axis_in  = 1'b0;
               state_in = req_payload.touched ? ST_MUL : ST_UPDATE;
            end
         end
         ST_MUL:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_status.done) begin
               axis_in  = 1'b1;
               state_in = axis_ff ? ST_UPDATE : ST_MUL;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Stability check against the previous touched position.
   assign dist_x   = (x_val_ff > prev_x_ff) ? x_val_ff - prev_x_ff : prev_x_ff - x_val_ff;
   assign dist_y   = (y_val_ff > prev_y_ff) ? y_val_ff - prev_y_ff : prev_y_ff - y_val_ff;
   assign stable_c = (POS_W'(dist_x) < POS_W'(tol_ff)) && (POS_W'(dist_y) < POS_W'(tol_ff));

   always_comb begin
      count_in  = count_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      pressed_c = 1'b0;
      if (touched_ff) begin
         if (stable_c) begin
            count_in = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 1'b1;
         end else begin
            count_in = '0;
         end
         prev_x_in = x_val_ff;
         prev_y_in = y_val_ff;
         if (count_in >= thr_ff) begin
            pressed_c = 1'b1;
            held_x_in = x_val_ff;
            held_y_in = y_val_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff  <= count_in;
            prev_x_ff <= prev_x_in;
            prev_y_ff <= prev_y_in;
            held_x_ff <= held_x_in;
            held_y_ff <= held_y_in;
         end
      end
   end

   // Output register holds the transaction until it is taken.
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_payload_ff.pressed <= pressed_c;
         rsp_payload_ff.x_pos   <= XPOS_W'(held_x_in);
         rsp_payload_ff.y_pos   <= YPOS_W'(held_y_in);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The divider is only started from the load step while it is idle.
   a_div_load: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while a division is running");

   // A finished division is only seen while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("division finished outside the wait step");

   // Every committed sample produces a pending result.
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid)
      else $error("committed sample produced no result");

   // The latched position never leaves the screen.
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (held_x_ff <= XW'(SCREEN_WIDTH - 1)) && (held_y_ff <= YW'(SCREEN_HEIGHT - 1)))
      else $error("stable position outside the screen");

endmodule
